/* design/cwf_pkg.sv */
// Shared types and constants for the command whitelist filter.
// No dependencies; imported by every module of the block except cwf_ram.
package cwf_pkg;

  // Default table depth, handed to the top-level parameter.
  localparam int unsigned CWF_TABLE_DEPTH = 256;
  // Number of channels that a table mask can name.
  localparam int unsigned CWF_CHANNEL_COUNT = 16;

  // Table entry layout: netfn 29..24, cmd 23..16, channel mask 15..0.
  localparam int unsigned CWF_ENTRY_W = 30;

  // Register port.
  localparam int unsigned CWF_ADDR_W = 5;
  localparam int unsigned CWF_DATA_W = 32;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_POST  = 3'd1;
  localparam logic [2:0] REG_SMM   = 3'd2;
  localparam logic [2:0] REG_SYS   = 3'd3;
  localparam logic [2:0] REG_TSIZE = 3'd4;

  // Restriction modes; anything above MODE_DENY denies as well.
  localparam logic [2:0] MODE_NONE      = 3'd0;
  localparam logic [2:0] MODE_ALLOW     = 3'd1;
  localparam logic [2:0] MODE_WHITELIST = 3'd2;
  localparam logic [2:0] MODE_DENY      = 3'd3;

  // Mailbox register B codes.
  localparam logic [7:0] MB_BIOS_DONE  = 8'h02;
  localparam logic [7:0] MB_BIOS_LOST0 = 8'h00;
  localparam logic [7:0] MB_BIOS_LOST1 = 8'h01;

  typedef enum logic [1:0] {
    REQ_FILTER = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_MBOX   = 2'd2,
    REQ_PRST   = 2'd3
  } cwf_req_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       post;
    logic [4:0] smm_chan;
    logic [3:0] sys_chan;
    logic [8:0] tsize;
  } cwf_cfg_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic capture;  // latch the incoming transaction, clear scan state
    logic scan_en;  // advance the table scan
    logic commit;   // update state and load the result register
  } cwf_ctl_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic in_is_filter;  // incoming transaction is a filter request
    logic scan_done;     // all searched entries compared
    logic hit;           // a matching entry was found
  } cwf_sts_t;

endpackage

/* design/cwf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the allowed-command table.
module cwf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cwf_regs.sv */
// APB-style configuration register file for the filter.
// Depends on cwf_pkg.
module cwf_regs
  import cwf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CWF_ADDR_W-1:0] paddr,
  input  logic [CWF_DATA_W-1:0] pwdata,
  output logic [CWF_DATA_W-1:0] prdata,
  output logic                  pready,
  output cwf_cfg_t              cfg_o
);

  cwf_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:  cfg_d.mode     = pwdata[2:0];
        REG_POST:  cfg_d.post     = pwdata[0];
        REG_SMM:   cfg_d.smm_chan = pwdata[4:0];
        REG_SYS:   cfg_d.sys_chan = pwdata[3:0];
        REG_TSIZE: cfg_d.tsize    = pwdata[8:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = {29'd0, cfg_q.mode};
      REG_POST:  prdata = {31'd0, cfg_q.post};
      REG_SMM:   prdata = {27'd0, cfg_q.smm_chan};
      REG_SYS:   prdata = {28'd0, cfg_q.sys_chan};
      REG_TSIZE: prdata = {23'd0, cfg_q.tsize};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= MODE_WHITELIST;
      cfg_q.post     <= 1'b0;
      cfg_q.smm_chan <= 5'd16;
      cfg_q.sys_chan <= 4'd15;
      cfg_q.tsize    <= 9'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/cwf_ctrl.sv */
// Controller state machine: accept, table scan, commit of the result.
// Depends on cwf_pkg.
module cwf_ctrl
  import cwf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  cwf_sts_t sts_i,
  output cwf_ctl_t ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new result when empty or drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  assign ctl_o.capture = (state_q == ST_IDLE) && in_valid_i;
  assign ctl_o.scan_en = (state_q == ST_SCAN);
  assign ctl_o.commit  = (state_q == ST_FINISH) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_is_filter ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* design/cwf_dp.sv */
// Datapath: request registers, table RAM and scan, BIOS-done tracking,
// filter decision and result register. Depends on cwf_pkg and cwf_ram.
module cwf_dp
  import cwf_pkg::*;
#(
  parameter int unsigned TableDepth = CWF_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cwf_cfg_t    cfg_i,
  input  cwf_ctl_t    ctl_i,
  output cwf_sts_t    sts_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  channel_i,
  input  logic [5:0]  netfn_i,
  input  logic [7:0]  cmd_i,
  input  logic [7:0]  entry_index_i,
  input  logic [15:0] entry_mask_i,
  input  logic [7:0]  event_byte_i,
  output logic        completion_code_o,
  output logic        clear_mailbox_b_o,
  output logic        bios_done_o
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW  = $clog2(TableDepth + 1);

  // Captured transaction
  cwf_req_e    req_q;
  logic [3:0]  chan_q;
  logic [5:0]  netfn_q;
  logic [7:0]  cmd_q;
  logic [7:0]  idx_q;
  logic [15:0] mask_q;
  logic [7:0]  ev_q;

  // Scan state
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            pend_q, pend_d;
  logic            hit_q, hit_d;
  logic [CntW-1:0] n_entries;
  logic [31:0]     n_full;
  logic            issue;
  logic            chan_ok;
  logic            match;

  // Tracked state
  logic       bios_q, bios_d;
  logic [7:0] last_mb_q, last_mb_d;

  // Result
  logic cc_d, clr_d;
  logic cc_q, clr_q, bdo_q;
  logic special_chan;

  // RAM
  logic                   ram_we;
  logic [CWF_ENTRY_W-1:0] ram_rdata;

  // Searched entries: table_size clipped to the table depth.
  assign n_full    = (32'(cfg_i.tsize) > 32'(TableDepth)) ? 32'(TableDepth)
                                                          : 32'(cfg_i.tsize);
  assign n_entries = CntW'(n_full);

  assign issue   = ctl_i.scan_en && (ptr_q < n_entries);
  assign chan_ok = 32'(chan_q) < 32'(CWF_CHANNEL_COUNT);
  assign match   = chan_ok && (ram_rdata[29:24] == netfn_q) &&
                   (ram_rdata[23:16] == cmd_q) && ram_rdata[chan_q];

  assign ram_we = ctl_i.commit && (req_q == REQ_LOAD) &&
                  (32'(idx_q) < 32'(TableDepth));

  cwf_ram #(
    .Width (CWF_ENTRY_W),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(idx_q)),
    .wdata_i ({netfn_q, cmd_q, mask_q}),
    .re_i    (issue),
    .raddr_i (AddrW'(ptr_q)),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ptr_d  = ptr_q;
    pend_d = pend_q;
    hit_d  = hit_q;
    if (ctl_i.capture) begin
      ptr_d  = '0;
      pend_d = 1'b0;
      hit_d  = 1'b0;
    end else if (ctl_i.scan_en) begin
      pend_d = issue;
      if (issue) begin
        ptr_d = ptr_q + CntW'(1);
      end
      if (pend_q && match) begin
        hit_d = 1'b1;
      end
    end
  end

  assign sts_o.in_is_filter = (cwf_req_e'(req_type_i) == REQ_FILTER);
  assign sts_o.scan_done    = (ptr_q == n_entries) && !pend_q;
  assign sts_o.hit          = hit_q;

  assign special_chan = (chan_q == cfg_i.sys_chan) || ({1'b0, chan_q} == cfg_i.smm_chan);

  always_comb begin
    bios_d    = bios_q;
    last_mb_d = last_mb_q;
    cc_d      = 1'b0;
    clr_d     = 1'b0;
    unique case (req_q)
      REQ_FILTER: begin
        if (!special_chan) begin
          cc_d = !hit_q;
        end else if (bios_q && cfg_i.post) begin
          case (cfg_i.mode) inside
            MODE_NONE, MODE_ALLOW: cc_d = 1'b0;
            MODE_WHITELIST:        cc_d = !hit_q;
            default:               cc_d = 1'b1;
          endcase
        end
      end
      REQ_LOAD: begin
        cc_d = 1'b0;
      end
      REQ_MBOX: begin
        if (ev_q != last_mb_q) begin
          last_mb_d = ev_q;
          if (!bios_q && (ev_q == MB_BIOS_DONE)) begin
            bios_d = 1'b1;
          end else if (bios_q && ((ev_q == MB_BIOS_LOST0) || (ev_q == MB_BIOS_LOST1))) begin
            bios_d = 1'b0;
          end
        end
      end
      REQ_PRST: begin
        if ((ev_q != 8'd0) && bios_q) begin
          bios_d = 1'b0;
          clr_d  = 1'b1;
        end
      end
      default: cc_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      hit_q     <= 1'b0;
      bios_q    <= 1'b0;
      last_mb_q <= 8'd0;
    end else begin
      ptr_q  <= ptr_d;
      pend_q <= pend_d;
      hit_q  <= hit_d;
      if (ctl_i.commit) begin
        bios_q    <= bios_d;
        last_mb_q <= last_mb_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      req_q   <= cwf_req_e'(req_type_i);
      chan_q  <= channel_i;
      netfn_q <= netfn_i;
      cmd_q   <= cmd_i;
      idx_q   <= entry_index_i;
      mask_q  <= entry_mask_i;
      ev_q    <= event_byte_i;
    end
    if (ctl_i.commit) begin
      cc_q  <= cc_d;
      clr_q <= clr_d;
      bdo_q <= bios_d;
    end
  end

  assign completion_code_o = cc_q;
  assign clear_mailbox_b_o = clr_q;
  assign bios_done_o       = bdo_q;

endmodule

/* design/command_whitelist_filter_top.sv */
// Command whitelist filter, top level: register file, controller, datapath.
// Depends on cwf_pkg, cwf_regs, cwf_ctrl, cwf_dp (and cwf_ram below it).
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  in      | to block  | in_valid_i / in_stall_o   | req_type, channel, netfn, cmd,
//          |           |                           | entry_index, entry_mask, event_byte
//  out     | from blk  | out_valid_o / out_stall_i | completion_code, clear_mailbox_b,
//          |           |                           | bios_done
//  cfg     | to block  | APB psel/penable/pready   | 5 registers at 4*i, 32-bit data
//
// Scan: a filter transaction reads the first min(table_size, TABLE_DEPTH) table
//   entries, one table entry per cycle through the single RAM read port, and
//   stops early on the first match; no new transaction is taken until the
//   current one is committed.
//   Load, mailbox and platform-reset transactions skip the scan.
// Reset: rst_ni is asynchronous, active low; it clears BIOS-done, the last
//   mailbox value and the registers. The table RAM is not cleared.
// Stalls: one result register sits at the output; the next transaction is
//   accepted while a result waits, and its result is held back until taken.
module command_whitelist_filter_top
  import cwf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = CWF_TABLE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            req_type_i,
  input  logic [3:0]            channel_i,
  input  logic [5:0]            netfn_i,
  input  logic [7:0]            cmd_i,
  input  logic [7:0]            entry_index_i,
  input  logic [15:0]           entry_mask_i,
  input  logic [7:0]            event_byte_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  completion_code_o,
  output logic                  clear_mailbox_b_o,
  output logic                  bios_done_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CWF_ADDR_W-1:0] paddr,
  input  logic [CWF_DATA_W-1:0] pwdata,
  output logic [CWF_DATA_W-1:0] prdata,
  output logic                  pready
);

  cwf_cfg_t cfg;
  cwf_ctl_t ctl;
  cwf_sts_t sts;

  // Registers are to be written only while no transaction is in flight; the block does not enforce it.
  cwf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencing: idle -> scan (filter only) -> finish (commit when result reg free).
  cwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Table, scan compare, BIOS-done tracking and the result register.
  cwf_dp #(
    .TableDepth (TABLE_DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .req_type_i        (req_type_i),
    .channel_i         (channel_i),
    .netfn_i           (netfn_i),
    .cmd_i             (cmd_i),
    .entry_index_i     (entry_index_i),
    .entry_mask_i      (entry_mask_i),
    .event_byte_i      (event_byte_i),
    .completion_code_o (completion_code_o),
    .clear_mailbox_b_o (clear_mailbox_b_o),
    .bios_done_o       (bios_done_o)
  );

  // An accepted transaction keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a transaction");

  // A result is never committed over one that is still held by a stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  // A mailbox clear request only comes with BIOS-done dropping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clear_mailbox_b_o) |-> !bios_done_o)
    else $error("clear request with BIOS-done still set");

  // A rejection is only given for a filter request, never with a clear request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && completion_code_o) |-> !clear_mailbox_b_o)
    else $error("rejection and clear request in one result");

endmodule

/* tb/tb_command_whitelist_filter_top.sv */
// Self-checking testbench for command_whitelist_filter_top: directed and random
// transactions checked against an in-bench allowlist predictor.
// Depends on cwf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb_command_whitelist_filter_top
  import cwf_pkg::*;
();

  localparam int unsigned TABLE_DEPTH = CWF_TABLE_DEPTH;
  localparam int unsigned HOLD_CYCLES = 400;      // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 300;     // > worst scan of 256 entries + overhead
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned POOL_N = 8;

  // One input transaction, field for field as the ports carry it.
  typedef struct packed {
    cwf_req_e    req;
    logic [3:0]  channel;
    logic [5:0]  netfn;
    logic [7:0]  cmd;
    logic [7:0]  idx;
    logic [15:0] mask;
    logic [7:0]  ev;
  } cmd_item_t;

  // One output transaction.
  typedef struct packed {
    logic cc;
    logic clr;
    logic bd;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT signals. Everything the bench drives starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  logic                  in_valid = 1'b0;
  cmd_item_t             cur = '0;
  logic                  out_stall = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CWF_ADDR_W-1:0] paddr = '0;
  logic [CWF_DATA_W-1:0] pwdata = '0;

  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  completion_code_o;
  logic                  clear_mailbox_b_o;
  logic                  bios_done_o;
  logic [CWF_DATA_W-1:0] prdata;
  logic                  pready;

  command_whitelist_filter_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .req_type_i        (cur.req),
    .channel_i         (cur.channel),
    .netfn_i           (cur.netfn),
    .cmd_i             (cur.cmd),
    .entry_index_i     (cur.idx),
    .entry_mask_i      (cur.mask),
    .event_byte_i      (cur.ev),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .completion_code_o (completion_code_o),
    .clear_mailbox_b_o (clear_mailbox_b_o),
    .bios_done_o       (bios_done_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: mirror of the table, BIOS-done tracking and the registers.
  // ---------------------------------------------------------------------------
  logic [CWF_ENTRY_W-1:0] shadow_tbl [TABLE_DEPTH];
  logic                   shadow_bios_done = 1'b0;
  logic [7:0]             shadow_mbox_b = 8'h00;
  cwf_cfg_t               shadow_cfg = '{mode: MODE_WHITELIST, post: 1'b0,
                                         smm_chan: 5'd16, sys_chan: 4'd15, tsize: 9'd0};

  cmd_item_t  pending_q [$];   // transactions waiting to be offered
  verdict_t   verdict_q [$];   // predicted results, oldest first

  // (netfn, cmd) pairs shared by table loads and filter requests so hits are common
  logic [5:0] pool_nf  [POOL_N];
  logic [7:0] pool_cmd [POOL_N];

  bit          src_idle_on = 1'b0;
  bit          snk_idle_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned src_wait = 0;
  int unsigned snk_wait = 0;

  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned deny_cnt = 0;
  int unsigned clear_cnt = 0;
  longint unsigned cycle_cnt = 0;

  function automatic int unsigned draw_gap(input bit on);
    return on ? $urandom_range(0, 17) : 0;
  endfunction

  // Membership test over the first min(table_size, depth) entries.
  function automatic logic table_hit(input logic [3:0] ch, input logic [5:0] nf,
                                     input logic [7:0] cd);
    int unsigned n;
    logic [CWF_ENTRY_W-1:0] e;
    n = (shadow_cfg.tsize > TABLE_DEPTH) ? TABLE_DEPTH : shadow_cfg.tsize;
    if (ch >= CWF_CHANNEL_COUNT) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      e = shadow_tbl[i];
      if (e[29:24] == nf && e[23:16] == cd && e[ch]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Completion code of a filter request: 0 allowed, 1 not available.
  function automatic logic filter_code(input logic [3:0] ch, input logic [5:0] nf,
                                       input logic [7:0] cd);
    logic hit;
    hit = table_hit(ch, nf, cd);
    if (ch != shadow_cfg.sys_chan && {1'b0, ch} != shadow_cfg.smm_chan) return ~hit;
    // host interfaces are open until BIOS-done and POST-complete both hold
    if (!shadow_bios_done || !shadow_cfg.post) return 1'b0;
    case (shadow_cfg.mode)
      MODE_NONE, MODE_ALLOW: return 1'b0;
      MODE_WHITELIST:        return ~hit;
      default:               return 1'b1;
    endcase
  endfunction

  // Advance the mirror by one accepted transaction and queue its result.
  function automatic void allowlist_step(input cmd_item_t it);
    verdict_t v;
    v = '0;
    case (it.req)
      REQ_FILTER: v.cc = filter_code(it.channel, it.netfn, it.cmd);
      REQ_LOAD: begin
        if (it.idx < TABLE_DEPTH) shadow_tbl[it.idx] = {it.netfn, it.cmd, it.mask};
      end
      REQ_MBOX: begin
        // only a changed mailbox value acts
        if (it.ev != shadow_mbox_b) begin
          shadow_mbox_b = it.ev;
          if (!shadow_bios_done && it.ev == MB_BIOS_DONE) begin
            shadow_bios_done = 1'b1;
          end else if (shadow_bios_done &&
                       (it.ev == MB_BIOS_LOST0 || it.ev == MB_BIOS_LOST1)) begin
            shadow_bios_done = 1'b0;
          end
        end
      end
      default: begin
        // platform reset: clears BIOS-done, keeps the last mailbox value
        if (it.ev != 8'h00 && shadow_bios_done) begin
          shadow_bios_done = 1'b0;
          v.clr = 1'b1;
        end
      end
    endcase
    v.bd = shadow_bios_done;
    verdict_q.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending transactions, holds payload while stalled, predicts on
  // acceptance. Exactly one NBA per signal per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      src_wait <= 0;
    end else begin
      gap = src_wait;
      if (in_valid && !in_stall_o) begin
        allowlist_step(cur);
        sent_cnt++;
        gap = draw_gap(src_idle_on);
      end
      if (in_valid && in_stall_o) begin
        // stalled: keep valid and payload as they are
      end else if (gap != 0) begin
        in_valid <= 1'b0;
        src_wait <= gap - 1;
      end else if (pending_q.size() != 0) begin
        cur      <= pending_q.pop_front();
        in_valid <= 1'b1;
        src_wait <= 0;
      end else begin
        in_valid <= 1'b0;
        src_wait <= 0;
      end
    end
  end

  // Long hold-off on the result side, counted here on its own.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results, compares each against the oldest prediction, and
  // draws a fresh stall stretch after every taken transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    int unsigned nxt;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      snk_wait  <= 0;
    end else begin
      nxt = (snk_wait != 0) ? snk_wait - 1 : 0;
      if (out_valid_o && !out_stall) begin
        result_cnt++;
        if (verdict_q.size() == 0) begin
          $error("result with nothing predicted: cc=%0d clr=%0d bd=%0d",
                 completion_code_o, clear_mailbox_b_o, bios_done_o);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (completion_code_o !== want.cc) begin
            $error("completion_code: expected %0d, got %0d", want.cc, completion_code_o);
            err_cnt++;
          end
          if (clear_mailbox_b_o !== want.clr) begin
            $error("clear_mailbox_b: expected %0d, got %0d", want.clr, clear_mailbox_b_o);
            err_cnt++;
          end
          if (bios_done_o !== want.bd) begin
            $error("bios_done: expected %0d, got %0d", want.bd, bios_done_o);
            err_cnt++;
          end
          if (want.cc) deny_cnt++;
          if (want.clr) clear_cnt++;
        end
        nxt = draw_gap(snk_idle_on);
      end
      snk_wait  <= nxt;
      out_stall <= (hold_left != 0) || (nxt != 0);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_command_whitelist_filter_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Fields a request type ignores still carry random bits.
  // ---------------------------------------------------------------------------
  function automatic cmd_item_t noise_item(input cwf_req_e r);
    cmd_item_t it;
    it.req     = r;
    it.channel = 4'($urandom);
    it.netfn   = 6'($urandom);
    it.cmd     = 8'($urandom);
    it.idx     = 8'($urandom);
    it.mask    = 16'($urandom);
    it.ev      = 8'($urandom);
    return it;
  endfunction

  function automatic void push_filter(input logic [3:0] ch, input logic [5:0] nf,
                                      input logic [7:0] cd);
    cmd_item_t it;
    it = noise_item(REQ_FILTER);
    it.channel = ch;
    it.netfn   = nf;
    it.cmd     = cd;
    pending_q.push_back(it);
  endfunction

  function automatic void push_load(input logic [7:0] slot, input logic [5:0] nf,
                                    input logic [7:0] cd, input logic [15:0] m);
    cmd_item_t it;
    it = noise_item(REQ_LOAD);
    it.idx   = slot;
    it.netfn = nf;
    it.cmd   = cd;
    it.mask  = m;
    pending_q.push_back(it);
  endfunction

  function automatic void push_event(input cwf_req_e r, input logic [7:0] b);
    cmd_item_t it;
    it = noise_item(r);
    it.ev = b;
    pending_q.push_back(it);
  endfunction

  // Random table content, mostly from the shared pool.
  function automatic void push_rand_load(input logic [7:0] slot);
    int unsigned p;
    p = $urandom_range(0, POOL_N - 1);
    if ($urandom_range(0, 9) < 7) push_load(slot, pool_nf[p], pool_cmd[p], 16'($urandom));
    else push_load(slot, 6'($urandom), 8'($urandom), 16'($urandom));
  endfunction

  // Random transaction mix; filters lean on the host channels and the pool.
  function automatic void push_rand_item();
    int unsigned sel;
    int unsigned p;
    logic [3:0] ch;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      case ($urandom_range(0, 4))
        0, 1:    ch = shadow_cfg.sys_chan;
        2:       ch = shadow_cfg.smm_chan[3:0];
        default: ch = 4'($urandom);
      endcase
      p = $urandom_range(0, POOL_N - 1);
      if ($urandom_range(0, 9) < 6) push_filter(ch, pool_nf[p], pool_cmd[p]);
      else push_filter(ch, 6'($urandom), 8'($urandom));
    end else if (sel < 65) begin
      push_rand_load(8'($urandom));
    end else if (sel < 90) begin
      case ($urandom_range(0, 6))
        0, 1, 2: push_event(REQ_MBOX, MB_BIOS_DONE);
        3:       push_event(REQ_MBOX, MB_BIOS_LOST0);
        4:       push_event(REQ_MBOX, MB_BIOS_LOST1);
        default: push_event(REQ_MBOX, 8'($urandom));
      endcase
    end else begin
      push_event(REQ_PRST, $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
    end
  endfunction

  // Wait until every transaction is accepted and every result has come back.
  task automatic drain();
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // APB write, then read back; only called while the block is idle.
  task automatic write_reg(input logic [2:0] ridx, input logic [CWF_DATA_W-1:0] val);
    logic [CWF_DATA_W-1:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);  // write lands at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (ridx)
      REG_MODE:  shadow_cfg.mode     = val[2:0];
      REG_POST:  shadow_cfg.post     = val[0];
      REG_SMM:   shadow_cfg.smm_chan = val[4:0];
      REG_SYS:   shadow_cfg.sys_chan = val[3:0];
      REG_TSIZE: shadow_cfg.tsize    = val[8:0];
      default: ;
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rd = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      $error("register %0d readback: expected %0h, got %0h", ridx, val, rd);
      err_cnt++;
    end
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [2:0] mode, input logic post,
                            input logic [4:0] smm, input logic [3:0] sys,
                            input logic [8:0] tsize);
    drain();
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_POST, 32'(post));
    write_reg(REG_SMM, 32'(smm));
    write_reg(REG_SYS, 32'(sys));
    write_reg(REG_TSIZE, 32'(tsize));
  endtask

  // ---------------------------------------------------------------------------
  // Directed part: table hits and misses, the mailbox and platform-reset rules,
  // every restriction mode with BIOS-done and POST-complete set.
  // ---------------------------------------------------------------------------
  task automatic run_directed();
    // registers are at reset: whitelist, POST not done, SMM none, system on 15
    push_load(8'd0, 6'h3F, 8'hFF, 16'hFFFF);
    push_load(8'd1, 6'h00, 8'h00, 16'h0001);
    push_load(8'd2, 6'h06, 8'h01, 16'h8000);
    push_load(8'd3, 6'h2A, 8'h55, 16'h0000);
    push_filter(4'd0, 6'h00, 8'h00);     // empty search -> not available
    drain();
    write_reg(REG_TSIZE, 32'd4);
    @(negedge clk_i);
    push_filter(4'd0, 6'h00, 8'h00);     // hit on channel 0
    push_filter(4'd15, 6'h3F, 8'hFF);    // system channel before BIOS-done: open
    push_filter(4'd5, 6'h06, 8'h01);     // mask lacks channel 5
    push_filter(4'd9, 6'h2A, 8'h55);     // empty mask never matches
    push_event(REQ_MBOX, MB_BIOS_DONE);  // sets BIOS-done
    push_event(REQ_MBOX, MB_BIOS_DONE);  // unchanged value, no action
    push_event(REQ_MBOX, 8'h05);         // stored only
    push_event(REQ_MBOX, MB_BIOS_LOST0); // clears BIOS-done
    push_event(REQ_MBOX, MB_BIOS_DONE);
    push_event(REQ_PRST, 8'h00);         // zero byte: nothing
    push_event(REQ_PRST, 8'hFF);         // clears BIOS-done, asks to clear mailbox
    push_event(REQ_PRST, 8'h01);         // BIOS-done already clear
    push_event(REQ_MBOX, MB_BIOS_DONE);  // equals stored value: still not done
    push_event(REQ_MBOX, MB_BIOS_LOST1);
    push_event(REQ_MBOX, MB_BIOS_DONE);  // now done again
    drain();
    write_reg(REG_POST, 32'd1);
    write_reg(REG_SMM, 32'd3);
    @(negedge clk_i);
    push_filter(4'd15, 6'h06, 8'h01);    // whitelist, hit on system channel
    push_filter(4'd3, 6'h06, 8'h01);     // whitelist, miss on SMM channel
    drain();
    write_reg(REG_MODE, 32'(MODE_DENY));
    @(negedge clk_i);
    push_filter(4'd15, 6'h3F, 8'hFF);
    drain();
    write_reg(REG_MODE, 32'(MODE_NONE));
    @(negedge clk_i);
    push_filter(4'd3, 6'h11, 8'h22);
    drain();
    write_reg(REG_MODE, 32'd7);          // unknown mode denies
    @(negedge clk_i);
    push_filter(4'd15, 6'h00, 8'h00);
    drain();
    write_reg(REG_MODE, 32'(MODE_ALLOW));
    write_reg(REG_SYS, 32'd0);
    @(negedge clk_i);
    push_filter(4'd0, 6'h3A, 8'h7E);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_items;
    logic [2:0]  m;
    logic        pc;
    logic [4:0]  smm;
    logic [3:0]  sys;
    logic [8:0]  ts;

    for (int i = 0; i < POOL_N; i++) begin
      pool_nf[i]  = 6'($urandom);
      pool_cmd[i] = 8'($urandom);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    run_directed();

    // Fill every slot so any table size searches written entries only.
    drain();
    for (int s = 0; s < TABLE_DEPTH; s++) push_rand_load(8'(s));

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0:       begin m = 3'd0; pc = 1'b1; smm = 5'd0;  sys = 4'd15; ts = 9'd256; end
        1:       begin m = 3'd7; pc = 1'b1; smm = 5'd31; sys = 4'd0;  ts = 9'd511; end
        2:       begin m = 3'd2; pc = 1'b1; smm = 5'd16; sys = 4'd15; ts = 9'd0;   end
        3:       begin m = 3'd2; pc = 1'b0; smm = 5'd5;  sys = 4'd9;  ts = 9'd1;   end
        4:       begin m = 3'd2; pc = 1'b1; smm = 5'd15; sys = 4'd15; ts = 9'd300; end
        5:       begin m = 3'd3; pc = 1'b1; smm = 5'd4;  sys = 4'd2;  ts = 9'd255; end
        default: begin
          m   = 3'($urandom_range(0, 7));
          pc  = ($urandom_range(0, 3) != 0);
          smm = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(16, 31))
                                            : 5'($urandom_range(0, 15));
          sys = 4'($urandom);
          ts  = ($urandom_range(0, 9) != 0) ? 9'($urandom_range(1, 24))
                                            : 9'($urandom_range(25, 511));
        end
      endcase
      set_config(m, pc, smm, sys, ts);
      // one stretch with no idling at all, the rest random
      src_idle_on = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      snk_idle_on = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      n_items = (ts > 64) ? 25 : 75;
      for (int k = 0; k < n_items; k++) push_rand_item();
    end

    // Pressure: back-to-back offers while the result side is held off, so the
    // output register fills and the block stalls its input.
    set_config(MODE_WHITELIST, 1'b1, 5'd6, 4'd7, 9'd8);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    for (int k = 0; k < 40; k++) push_rand_item();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d transactions sent, %0d results checked (%0d denied, %0d mailbox clears)",
             sent_cnt, result_cnt, deny_cnt, clear_cnt);
    $display("summary: all restriction modes, table sizes 0..511, long output hold-off");
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("tb_command_whitelist_filter_top: done, clean");
    end else begin
      $display("tb_command_whitelist_filter_top: done, errors");
    end
    $finish;
  end

endmodule

/* command_whitelist_filter_top.f */
design/cwf_pkg.sv
design/cwf_ram.sv
design/cwf_regs.sv
design/cwf_ctrl.sv
design/cwf_dp.sv
design/command_whitelist_filter_top.sv
tb/tb_command_whitelist_filter_top.sv
